@@ rtl/wsd_pkg.sv @@
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and codes for the WebSocket receive-side frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

    // Parser phases
    localparam logic [2:0] PH_HDR0    = 3'd0;
    localparam logic [2:0] PH_HDR1    = 3'd1;
    localparam logic [2:0] PH_EXT16   = 3'd2;
    localparam logic [2:0] PH_EXT64   = 3'd3;
    localparam logic [2:0] PH_MASK    = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;

    // Result kinds
    localparam logic [1:0] KIND_DATA      = 2'd0;
    localparam logic [1:0] KIND_EMPTY     = 2'd1;
    localparam logic [1:0] KIND_OVERSIZE  = 2'd2;
    localparam logic [1:0] KIND_TRUNCATED = 2'd3;

    // 7-bit length escapes
    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    // Last extended-length and masking-key byte indices (counted from zero)
    localparam logic [2:0] EXT16_LAST = 3'd1;
    localparam logic [2:0] EXT64_LAST = 3'd7;
    localparam logic [2:0] KEY_LAST   = 3'd3;

    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd8178;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       abort;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       frame_fin;
        logic [3:0] frame_opcode;
        logic       last_of_frame;
        logic [1:0] result_kind;
    } out_beat_t;

    // Input register contents handed to the parser
    typedef struct packed {
        logic     valid;
        in_beat_t beat;
    } staged_t;

    // Parser result handed to the output register
    typedef struct packed {
        logic      valid;
        out_beat_t beat;
    } result_t;

endpackage

@@ rtl/wsd_in_stage.sv @@
// ----------------------------------------------------------------------------
// wsd_in_stage
// Input register: holds one received beat until the parser takes it.
// ----------------------------------------------------------------------------
module wsd_in_stage
    import wsd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_beat_t in_data,
    input  logic     take,
    output staged_t  staged
);

    logic     valid_reg;
    in_beat_t beat_reg;

    // Refill in the same cycle the held beat is taken
    assign in_ready = !valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            beat_reg <= in_data;
        end
    end

    assign staged.valid = valid_reg;
    assign staged.beat  = beat_reg;

endmodule

@@ rtl/wsd_parser.sv @@
// ----------------------------------------------------------------------------
// wsd_parser
// Frame header/length/key parser and payload unmasking, one byte per take.
// ----------------------------------------------------------------------------
module wsd_parser
    import wsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  staged_t     staged,
    input  logic        take,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    output result_t     res
);

    logic [31:0] max_len_reg;
    logic [2:0]  phase_reg,   phase_next;
    logic        fin_reg,     fin_next;
    logic [3:0]  opcode_reg,  opcode_next;
    logic        mask_reg,    mask_next;
    logic [63:0] acc_reg,     acc_next;
    logic [2:0]  hbc_reg,     hbc_next;
    logic [31:0] key_reg,     key_next;
    logic [63:0] rem_reg,     rem_next;
    logic [1:0]  kidx_reg,    kidx_next;
    logic        discard_reg, discard_next;

    logic [7:0]  b;
    logic        abort;
    logic [63:0] acc_sh;
    logic [63:0] len_val;
    logic [63:0] hdr_len;
    logic        hdr_discard;
    logic        do_len;
    logic        do_hdr;
    logic        clr;
    logic        over;
    logic        ext_last;
    logic [7:0]  key_byte;
    logic        emit;
    logic [7:0]  emit_byte;
    logic        emit_last;
    logic [1:0]  emit_kind;

    assign b      = staged.beat.data_byte;
    assign abort  = staged.beat.abort;
    assign acc_sh = {acc_reg[55:0], b};

    always_comb
    begin
        case (kidx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next   = phase_reg;
        fin_next     = fin_reg;
        opcode_next  = opcode_reg;
        mask_next    = mask_reg;
        acc_next     = acc_reg;
        hbc_next     = hbc_reg;
        key_next     = key_reg;
        rem_next     = rem_reg;
        kidx_next    = kidx_reg;
        discard_next = discard_reg;
        do_len       = 1'b0;
        do_hdr       = 1'b0;
        clr          = 1'b0;
        over         = 1'b0;
        ext_last     = 1'b0;
        len_val      = '0;
        hdr_len      = rem_reg;
        hdr_discard  = discard_reg;
        emit         = 1'b0;
        emit_byte    = 8'd0;
        emit_last    = 1'b1;
        emit_kind    = KIND_DATA;

        if (take)
        begin
            if (abort)
            begin
                // Truncation only reported for an open, non-discarded frame
                if (phase_reg != PH_HDR0 && !discard_reg)
                begin
                    emit      = 1'b1;
                    emit_kind = KIND_TRUNCATED;
                end
                clr = 1'b1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_HDR0:
                    begin
                        fin_next    = b[7];
                        opcode_next = b[3:0];
                        phase_next  = PH_HDR1;
                    end
                    PH_HDR1:
                    begin
                        mask_next = b[7];
                        acc_next  = '0;
                        hbc_next  = '0;
                        if (b[6:0] == LEN7_EXT16)
                        begin
                            phase_next = PH_EXT16;
                        end
                        else if (b[6:0] == LEN7_EXT64)
                        begin
                            phase_next = PH_EXT64;
                        end
                        else
                        begin
                            do_len  = 1'b1;
                            len_val = {57'd0, b[6:0]};
                        end
                    end
                    PH_EXT16, PH_EXT64:
                    begin
                        acc_next = acc_sh;
                        ext_last = (phase_reg == PH_EXT16) ? (hbc_reg == EXT16_LAST)
                                                           : (hbc_reg == EXT64_LAST);
                        if (ext_last)
                        begin
                            do_len  = 1'b1;
                            len_val = acc_sh;
                        end
                        else
                        begin
                            hbc_next = hbc_reg + 3'd1;
                        end
                    end
                    PH_MASK:
                    begin
                        key_next = {key_reg[23:0], b};
                        if (hbc_reg >= KEY_LAST)
                        begin
                            hbc_next = '0;
                            do_hdr   = 1'b1;
                        end
                        else
                        begin
                            hbc_next = hbc_reg + 3'd1;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        if (rem_reg == 64'd0)
                        begin
                            clr = 1'b1;
                        end
                        else
                        begin
                            emit_last = (rem_reg == 64'd1);
                            if (!discard_reg)
                            begin
                                emit      = 1'b1;
                                emit_kind = KIND_DATA;
                                emit_byte = mask_reg ? (b ^ key_byte) : b;
                            end
                            kidx_next = kidx_reg + 2'd1;
                            rem_next  = rem_reg - 64'd1;
                            clr       = emit_last;
                        end
                    end
                    default:
                    begin
                        clr = 1'b1;
                    end
                endcase

                // Full length known
                if (do_len)
                begin
                    rem_next    = len_val;
                    hbc_next    = '0;
                    over        = (len_val[63:32] != 32'd0) || (len_val[31:0] > max_len_reg);
                    hdr_len     = len_val;
                    hdr_discard = discard_reg || over;
                    if (over)
                    begin
                        discard_next = 1'b1;
                        emit         = 1'b1;
                        emit_kind    = KIND_OVERSIZE;
                    end
                    if (mask_next)
                    begin
                        phase_next = PH_MASK;
                    end
                    else
                    begin
                        do_hdr = 1'b1;
                    end
                end

                // Header complete (length and any key)
                if (do_hdr)
                begin
                    kidx_next = '0;
                    if (hdr_len == 64'd0)
                    begin
                        if (!hdr_discard)
                        begin
                            emit      = 1'b1;
                            emit_kind = KIND_EMPTY;
                        end
                        clr = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end

            if (clr)
            begin
                phase_next   = PH_HDR0;
                fin_next     = 1'b0;
                opcode_next  = '0;
                mask_next    = 1'b0;
                acc_next     = '0;
                hbc_next     = '0;
                key_next     = '0;
                rem_next     = '0;
                kidx_next    = '0;
                discard_next = 1'b0;
            end
        end
    end

    // Fin/opcode come from the frame being closed, before any clear
    assign res.valid              = emit;
    assign res.beat.payload_byte  = emit_byte;
    assign res.beat.frame_fin     = fin_reg;
    assign res.beat.frame_opcode  = opcode_reg;
    assign res.beat.last_of_frame = emit_last;
    assign res.beat.result_kind   = emit_kind;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_PAYLOAD_RESET;
            phase_reg   <= PH_HDR0;
            fin_reg     <= 1'b0;
            opcode_reg  <= '0;
            mask_reg    <= 1'b0;
            acc_reg     <= '0;
            hbc_reg     <= '0;
            key_reg     <= '0;
            rem_reg     <= '0;
            kidx_reg    <= '0;
            discard_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_len_reg <= cfg_wr_data;
            end
            phase_reg   <= phase_next;
            fin_reg     <= fin_next;
            opcode_reg  <= opcode_next;
            mask_reg    <= mask_next;
            acc_reg     <= acc_next;
            hbc_reg     <= hbc_next;
            key_reg     <= key_next;
            rem_reg     <= rem_next;
            kidx_reg    <= kidx_next;
            discard_reg <= discard_next;
        end
    end

    // Only a held beat is ever parsed
    a_take_held: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> staged.valid)
        else $error("parse with no beat held");

    // Data beats only come out of the payload phase
    a_data_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.beat.result_kind == KIND_DATA) |-> (phase_reg == PH_PAYLOAD))
        else $error("data beat outside payload phase");

    // Every non-data result is flagged as the last beat of its frame
    a_nondata_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.beat.result_kind != KIND_DATA) |-> res.beat.last_of_frame)
        else $error("non-data result without last flag");

    // A skipped frame never produces data
    a_discard_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (take && discard_reg && !abort) |-> !res.valid)
        else $error("result while discarding");

    // Abort returns the parser to the idle header state
    a_abort_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (take && abort) |=> (phase_reg == PH_HDR0 && rem_reg == 64'd0 && !discard_reg))
        else $error("parser not cleared after abort");

    // Payload phase always has bytes outstanding
    a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (rem_reg != 64'd0))
        else $error("payload phase with nothing remaining");

endmodule

@@ rtl/wsd_out_stage.sv @@
// ----------------------------------------------------------------------------
// wsd_out_stage
// Result register: holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module wsd_out_stage
    import wsd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  result_t   res,
    input  logic      take,
    output logic      slot_free,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_data
);

    logic      valid_reg;
    out_beat_t beat_reg;

    assign slot_free = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= res.valid;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && res.valid)
        begin
            beat_reg <= res.beat;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = beat_reg;

endmodule

@@ rtl/websocket_frame_deframer_top.sv @@
// Path: a byte accepted into the input register is parsed when taken, and its
// result beat, if any, is captured in the result register and held on the output.
// Throughput: one byte per cycle sustained; set by the single parser pass between
// the input register and the result register. Stalls only while a result beat is
// held and out_ready is low.
// Reset: rst_n asynchronous, active low; parser idle, max length 8178.
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top
// WebSocket receive-side deframer: parses frame headers, extended lengths and
// masking keys from a byte stream and emits unmasked payload beats, empty-frame
// markers, oversize errors and truncation errors.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_top
    import wsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // byte stream in
    input  logic        in_valid,
    output logic        in_ready,
    input  in_beat_t    in_data,
    // result beats out
    output logic        out_valid,
    input  logic        out_ready,
    output out_beat_t   out_data,
    // max payload length register
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data
);

    staged_t staged;
    result_t res;
    logic    slot_free;
    logic    take;

    // A held byte is parsed whenever the result register can take whatever
    // it produces; bytes that produce nothing still wait for a free slot,
    // which keeps the control simple and costs nothing in steady flow.
    assign take = staged.valid && slot_free;

    // Input register
    wsd_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .take     (take),
        .staged   (staged)
    );

    // Header, length and key parsing; payload unmasking with key byte index
    // mod 4; oversize frames are flagged once and then skipped silently.
    wsd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .staged      (staged),
        .take        (take),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .res         (res)
    );

    // Result register; frees in the same cycle the consumer takes a beat
    wsd_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .take      (take),
        .slot_free (slot_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
